### hw/rtl/out_of_order_issue_scheduler_top_assert.svh
// Assertion macros for the out-of-order issue scheduler.
// Used by hw/rtl/out_of_order_issue_scheduler_top.sv; empty when SYNTHESIS is set.
`ifndef OUT_OF_ORDER_ISSUE_SCHEDULER_TOP_ASSERT_SVH
`define OUT_OF_ORDER_ISSUE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OOIS_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("scheduler assertion failed");
`define OOIS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`else
`define OOIS_ASSERT_HOLDS(lbl, expr)
`define OOIS_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

### hw/rtl/oois_pkg.sv
// Shared types, constants and helpers of the out-of-order issue scheduler.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package oois_pkg;

  localparam int unsigned WIN_DEPTH       = 64;
  localparam int unsigned WIN_W           = 6;
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned MAX_WIDTH       = 8;
  localparam int unsigned MAX_QUEUE       = 64;
  localparam int unsigned REG_COUNT       = 128;
  localparam int unsigned REG_W           = 7;
  localparam int unsigned WORDS_PER_ENTRY = 6;
  localparam int unsigned WRAM_DEPTH      = WIN_DEPTH * WORDS_PER_ENTRY;
  localparam int unsigned WRAM_AW         = 9;
  localparam int unsigned DL_W            = 5;
  localparam int unsigned REM_W           = 3;
  localparam int unsigned CFG_IDX_W       = 8;

  typedef logic [WIN_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DL_W-1:0]    dl_t;
  typedef logic [WRAM_AW-1:0] waddr_t;
  typedef logic [REG_W-1:0]   rtag_t;
  typedef logic [REM_W-1:0]   rem_t;
  typedef logic [2:0]         slot_t;

  typedef enum logic [2:0] {
    ST_EMPTY, ST_IF, ST_ID, ST_IS, ST_EX, ST_WB
  } stage_e;

  localparam logic       OP_FETCH = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [1:0] RK_ACCEPT = 2'd0;
  localparam logic [1:0] RK_REFUSE = 2'd1;
  localparam logic [1:0] RK_RETIRE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QSIZE = 8'd1;

  // Word slots of one window entry in the window memory
  localparam slot_t TS_FETCH  = 3'd0;
  localparam slot_t TS_DECODE = 3'd1;
  localparam slot_t TS_QUEUE  = 3'd2;
  localparam slot_t TS_EXEC   = 3'd3;
  localparam slot_t TS_WB     = 3'd4;
  localparam slot_t TS_REGS   = 3'd5;

  function automatic waddr_t win_addr(idx_t e, slot_t k);
    return waddr_t'(e) * waddr_t'(WORDS_PER_ENTRY) + waddr_t'(k);
  endfunction

  function automatic rem_t lat_of(logic [1:0] fu);
    rem_t r;
    unique case (fu)
      2'd0:    r = 3'd1;
      2'd1:    r = 3'd2;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic reg_ok(logic [7:0] r);
    return {1'b0, r} < 9'(REG_COUNT);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/oois_if.sv
// Handshake channels of the scheduler: input, result and configuration.
// Depends on oois_pkg for the index width.
`default_nettype none
interface oois_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [1:0]        fu_type;
  logic signed [7:0] dest_reg;
  logic signed [7:0] src1_reg;
  logic signed [7:0] src2_reg;
  modport source(output valid, operation, fu_type, dest_reg, src1_reg, src2_reg,
                 input ready);
  modport sink(input valid, operation, fu_type, dest_reg, src1_reg, src2_reg,
               output ready);
endinterface

interface oois_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [31:0]       seq_tag;
  logic [1:0]        unit_type;
  logic signed [7:0] dest_out;
  logic signed [7:0] src1_out;
  logic signed [7:0] src2_out;
  logic [31:0]       fetch_cycle;
  logic [31:0]       decode_cycle;
  logic [31:0]       queue_cycle;
  logic [31:0]       exec_cycle;
  logic [31:0]       writeback_cycle;
  logic              last_of_run;
  modport source(output valid, result_kind, seq_tag, unit_type, dest_out, src1_out,
                 src2_out, fetch_cycle, decode_cycle, queue_cycle, exec_cycle,
                 writeback_cycle, last_of_run, input ready);
  modport sink(input valid, result_kind, seq_tag, unit_type, dest_out, src1_out,
               src2_out, fetch_cycle, decode_cycle, queue_cycle, exec_cycle,
               writeback_cycle, last_of_run, output ready);
endinterface

interface oois_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [oois_pkg::CFG_IDX_W-1:0]       index;
  logic [31:0]                          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/oois_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module oois_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/out_of_order_issue_scheduler_top.sv
// Out-of-order issue scheduler: window payload and stage times in one RAM,
// rename tags in a second RAM, per-entry control in flip-flops.
// Fetch: the result is registered in the cycle after acceptance; a new item is taken only in S_IDLE once it is taken.
// Tick: retires finished head records, completes executing entries, issues over the window,
//   dispatches from the decode list and advances fetched entries to decode.
// Reset: asynchronous; control and rename valid bits clear at once, no clearing pass.
`default_nettype none
`include "out_of_order_issue_scheduler_top_assert.svh"
module out_of_order_issue_scheduler_top (
  input  wire            clk_i,
  input  wire            rst_ni,
  oois_in_if.sink        in_i,
  oois_out_if.source     out_o,
  oois_cfg_if.sink       cfg_i
);
  localparam int unsigned WD = oois_pkg::WIN_DEPTH;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH2, S_RET_CHECK, S_RET_RD, S_RET_CAP, S_EX_START, S_EX_SCAN,
    S_EX_REN, S_EX_CMP, S_IS_START, S_IS_SCAN, S_DS_START, S_DS_SCAN, S_DS_R1,
    S_DS_R2, S_DS_R3, S_DEC_START, S_DEC_SCAN
  } state_e;

  state_e state_q;

  oois_pkg::stage_e stage_q [WD];
  logic [1:0]       fu_q    [WD];
  logic             w1v_q   [WD];
  logic             w2v_q   [WD];
  oois_pkg::idx_t   w1t_q   [WD];
  oois_pkg::idx_t   w2t_q   [WD];
  oois_pkg::rem_t   rem_q   [WD];
  logic [oois_pkg::REG_COUNT-1:0] ren_v_q;

  logic [31:0]      cycle_q, seq_q;
  logic [3:0]       fetched_q, width_q, taken_q;
  oois_pkg::idx_t   head_q, base_q, cur_e_q;
  oois_pkg::cnt_t   count_q, iscount_q, qsize_q, pos_q;
  oois_pkg::dl_t    dcount_q, lim_q, moved_q;
  logic [WD-1:0]    done_q;
  oois_pkg::slot_t  rk_q;
  logic [7:0]       dst_q, s1_q, s2_q;

  logic              out_valid_q, last_q;
  logic [1:0]        kind_q, unit_q;
  logic [31:0]       tag_q, t0_q, t1_q, t2_q, t3_q, t4_q;
  logic signed [7:0] dout_q, s1out_q, s2out_q;

  // RAM ports
  logic                          wram_we, wram_re;
  oois_pkg::waddr_t              wram_waddr, wram_raddr;
  logic [31:0]                   wram_wdata, wram_rdata;
  logic                          rram_we, rram_re;
  oois_pkg::rtag_t               rram_waddr, rram_raddr;
  oois_pkg::idx_t                rram_wdata, rram_rdata;

  logic [3:0]       w_eff;
  oois_pkg::cnt_t   q_eff, freeq, lim_full;
  logic             in_fire, fetch_ok;
  oois_pkg::idx_t   tail, scan_e, first_e, next_head;
  logic [WD-1:0]    done_d;
  logic [31:0]      regs_word;

  assign w_eff    = (width_q > 4'(oois_pkg::MAX_WIDTH)) ? 4'(oois_pkg::MAX_WIDTH) : width_q;
  assign q_eff    = (qsize_q > 7'(oois_pkg::MAX_QUEUE)) ? 7'(oois_pkg::MAX_QUEUE) : qsize_q;
  assign freeq    = (q_eff > iscount_q) ? (q_eff - iscount_q) : '0;
  assign lim_full = (freeq < 7'(dcount_q)) ? freeq : 7'(dcount_q);

  assign in_i.ready  = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign tail        = head_q + count_q[oois_pkg::WIN_W-1:0];
  assign scan_e      = base_q + pos_q[oois_pkg::WIN_W-1:0];
  assign next_head   = head_q + oois_pkg::idx_t'(1);
  assign fetch_ok    = (w_eff != 4'd0) && (fetched_q < w_eff)
                     && (dcount_q < {w_eff, 1'b0}) && (count_q < 7'(WD));
  assign regs_word   = {6'd0, in_i.fu_type, in_i.dest_reg, in_i.src1_reg, in_i.src2_reg};

  always_comb begin
    for (int i = 0; i < WD; i++) begin
      done_d[i] = (stage_q[i] == oois_pkg::ST_EX) && (rem_q[i] <= 3'd1);
    end
  end

  // Lowest pending completion first
  always_comb begin
    first_e = '0;
    for (int i = WD - 1; i >= 0; i--) begin
      if (done_q[i]) first_e = oois_pkg::idx_t'(i);
    end
  end

  always_comb begin
    wram_we    = 1'b0;
    wram_waddr = '0;
    wram_wdata = cycle_q;
    wram_re    = 1'b0;
    wram_raddr = '0;
    rram_we    = 1'b0;
    rram_waddr = dst_q[oois_pkg::REG_W-1:0];
    rram_wdata = cur_e_q;
    rram_re    = 1'b0;
    rram_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        wram_we    = in_fire && (in_i.operation == oois_pkg::OP_FETCH) && fetch_ok;
        wram_waddr = oois_pkg::win_addr(tail, oois_pkg::TS_REGS);
        wram_wdata = regs_word;
      end
      S_FETCH2: begin
        wram_we    = 1'b1;
        wram_waddr = oois_pkg::win_addr(cur_e_q, oois_pkg::TS_FETCH);
      end
      S_RET_RD: begin
        wram_re    = 1'b1;
        wram_raddr = oois_pkg::win_addr(head_q, rk_q);
      end
      S_EX_SCAN: begin
        wram_we    = (done_q != '0);
        wram_waddr = oois_pkg::win_addr(first_e, oois_pkg::TS_WB);
        wram_re    = (done_q != '0);
        wram_raddr = oois_pkg::win_addr(first_e, oois_pkg::TS_REGS);
      end
      S_EX_REN: begin
        rram_re    = 1'b1;
        rram_raddr = wram_rdata[16 +: oois_pkg::REG_W];
      end
      S_IS_SCAN: begin
        wram_we    = (pos_q != count_q) && (stage_q[head_q + pos_q[5:0]] == oois_pkg::ST_IS)
                   && (taken_q < w_eff) && !w1v_q[head_q + pos_q[5:0]]
                   && !w2v_q[head_q + pos_q[5:0]];
        wram_waddr = oois_pkg::win_addr(head_q + pos_q[5:0], oois_pkg::TS_EXEC);
      end
      S_DS_SCAN: begin
        wram_re    = (pos_q != 7'(lim_q)) && (stage_q[scan_e] == oois_pkg::ST_ID);
        wram_raddr = oois_pkg::win_addr(scan_e, oois_pkg::TS_REGS);
      end
      S_DS_R1: begin
        rram_re    = 1'b1;
        rram_raddr = wram_rdata[8 +: oois_pkg::REG_W];
      end
      S_DS_R2: begin
        rram_re    = 1'b1;
        rram_raddr = s2_q[oois_pkg::REG_W-1:0];
      end
      S_DS_R3: begin
        rram_we    = oois_pkg::reg_ok(dst_q);
        wram_we    = 1'b1;
        wram_waddr = oois_pkg::win_addr(cur_e_q, oois_pkg::TS_QUEUE);
      end
      S_DEC_SCAN: begin
        wram_we    = (pos_q != 7'(dcount_q)) && (stage_q[scan_e] == oois_pkg::ST_IF);
        wram_waddr = oois_pkg::win_addr(scan_e, oois_pkg::TS_DECODE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < WD; i++) begin
        stage_q[i] <= oois_pkg::ST_EMPTY;
        fu_q[i]    <= '0;
        w1v_q[i]   <= 1'b0;
        w2v_q[i]   <= 1'b0;
        w1t_q[i]   <= '0;
        w2t_q[i]   <= '0;
        rem_q[i]   <= '0;
      end
      ren_v_q     <= '0;
      cycle_q     <= '0;
      seq_q       <= '0;
      fetched_q   <= '0;
      width_q     <= 4'd4;
      qsize_q     <= 7'd32;
      taken_q     <= '0;
      head_q      <= '0;
      base_q      <= '0;
      cur_e_q     <= '0;
      count_q     <= '0;
      iscount_q   <= '0;
      pos_q       <= '0;
      dcount_q    <= '0;
      lim_q       <= '0;
      moved_q     <= '0;
      done_q      <= '0;
      rk_q        <= '0;
      dst_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= '0;
      unit_q      <= '0;
      tag_q       <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      t4_q        <= '0;
      dout_q      <= '0;
      s1out_q     <= '0;
      s2out_q     <= '0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      if (cfg_i.valid && cfg_i.ready) begin
        priority if (cfg_i.index == oois_pkg::CFG_WIDTH) width_q <= cfg_i.data[3:0];
        else if (cfg_i.index == oois_pkg::CFG_QSIZE) qsize_q <= cfg_i.data[6:0];
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.operation == oois_pkg::OP_FETCH) begin
              out_valid_q <= 1'b1;
              unit_q  <= '0;
              dout_q  <= '0;
              s1out_q <= '0;
              s2out_q <= '0;
              t0_q    <= '0;
              t1_q    <= '0;
              t2_q    <= '0;
              t3_q    <= '0;
              t4_q    <= '0;
              last_q  <= 1'b0;
              if (fetch_ok) begin
                kind_q         <= oois_pkg::RK_ACCEPT;
                tag_q          <= seq_q;
                stage_q[tail]  <= oois_pkg::ST_IF;
                fu_q[tail]     <= in_i.fu_type;
                w1v_q[tail]    <= 1'b0;
                w2v_q[tail]    <= 1'b0;
                rem_q[tail]    <= '0;
                count_q        <= count_q + 7'd1;
                dcount_q       <= dcount_q + 5'd1;
                fetched_q      <= fetched_q + 4'd1;
                seq_q          <= seq_q + 32'd1;
                cur_e_q        <= tail;
                state_q        <= S_FETCH2;
              end else begin
                kind_q <= oois_pkg::RK_REFUSE;
                tag_q  <= '0;
              end
            end else begin
              cycle_q   <= cycle_q + 32'd1;
              fetched_q <= '0;
              state_q   <= S_RET_CHECK;
            end
          end
        end
        S_FETCH2: state_q <= S_IDLE;
        S_RET_CHECK: begin
          if ((count_q != '0) && (stage_q[head_q] == oois_pkg::ST_WB)) begin
            // hold until the previous transaction has been taken
            if (!out_valid_q) begin
              rk_q    <= oois_pkg::TS_FETCH;
              state_q <= S_RET_RD;
            end
          end else begin
            state_q <= S_EX_START;
          end
        end
        S_RET_RD: state_q <= S_RET_CAP;
        S_RET_CAP: begin
          unique case (rk_q)
            oois_pkg::TS_FETCH:  t0_q <= wram_rdata;
            oois_pkg::TS_DECODE: t1_q <= wram_rdata;
            oois_pkg::TS_QUEUE:  t2_q <= wram_rdata;
            oois_pkg::TS_EXEC:   t3_q <= wram_rdata;
            oois_pkg::TS_WB:     t4_q <= wram_rdata;
            default: begin
              unit_q  <= wram_rdata[25:24];
              dout_q  <= wram_rdata[23:16];
              s1out_q <= wram_rdata[15:8];
              s2out_q <= wram_rdata[7:0];
            end
          endcase
          if (rk_q == oois_pkg::TS_REGS) begin
            kind_q          <= oois_pkg::RK_RETIRE;
            tag_q           <= seq_q - 32'(count_q);
            last_q          <= (count_q == 7'd1) || (stage_q[next_head] != oois_pkg::ST_WB);
            out_valid_q     <= 1'b1;
            stage_q[head_q] <= oois_pkg::ST_EMPTY;
            head_q          <= next_head;
            count_q         <= count_q - 7'd1;
            state_q         <= S_RET_CHECK;
          end else begin
            rk_q    <= rk_q + 3'd1;
            state_q <= S_RET_RD;
          end
        end
        S_EX_START: begin
          for (int i = 0; i < WD; i++) begin
            if (stage_q[i] == oois_pkg::ST_EX) begin
              if (rem_q[i] > 3'd1) begin
                rem_q[i] <= rem_q[i] - 3'd1;
              end else begin
                rem_q[i]   <= '0;
                stage_q[i] <= oois_pkg::ST_WB;
              end
            end
            // wake every source whose producer completes on this tick
            if (w1v_q[i] && done_d[w1t_q[i]]) w1v_q[i] <= 1'b0;
            if (w2v_q[i] && done_d[w2t_q[i]]) w2v_q[i] <= 1'b0;
          end
          done_q  <= done_d;
          state_q <= S_EX_SCAN;
        end
        S_EX_SCAN: begin
          if (done_q == '0) begin
            state_q <= S_IS_START;
          end else begin
            cur_e_q         <= first_e;
            done_q[first_e] <= 1'b0;
            state_q         <= S_EX_REN;
          end
        end
        S_EX_REN: begin
          dst_q <= wram_rdata[23:16];
          if (oois_pkg::reg_ok(wram_rdata[23:16])
              && ren_v_q[wram_rdata[16 +: oois_pkg::REG_W]]) begin
            state_q <= S_EX_CMP;
          end else begin
            state_q <= S_EX_SCAN;
          end
        end
        S_EX_CMP: begin
          if (rram_rdata == cur_e_q) ren_v_q[dst_q[oois_pkg::REG_W-1:0]] <= 1'b0;
          state_q <= S_EX_SCAN;
        end
        S_IS_START: begin
          pos_q   <= '0;
          taken_q <= '0;
          state_q <= S_IS_SCAN;
        end
        S_IS_SCAN: begin
          if (pos_q == count_q) begin
            state_q <= S_DS_START;
          end else begin
            if (wram_we) begin
              stage_q[head_q + pos_q[5:0]] <= oois_pkg::ST_EX;
              rem_q[head_q + pos_q[5:0]]   <= oois_pkg::lat_of(fu_q[head_q + pos_q[5:0]]);
              taken_q   <= taken_q + 4'd1;
              iscount_q <= iscount_q - 7'd1;
            end
            pos_q <= pos_q + 7'd1;
          end
        end
        S_DS_START: begin
          lim_q   <= lim_full[oois_pkg::DL_W-1:0];
          pos_q   <= '0;
          moved_q <= '0;
          base_q  <= head_q + oois_pkg::idx_t'(count_q - 7'(dcount_q));
          state_q <= S_DS_SCAN;
        end
        S_DS_SCAN: begin
          if (pos_q == 7'(lim_q)) begin
            dcount_q <= dcount_q - moved_q;
            state_q  <= S_DEC_START;
          end else if (stage_q[scan_e] == oois_pkg::ST_ID) begin
            cur_e_q <= scan_e;
            state_q <= S_DS_R1;
          end else begin
            pos_q <= pos_q + 7'd1;
          end
        end
        S_DS_R1: begin
          dst_q   <= wram_rdata[23:16];
          s1_q    <= wram_rdata[15:8];
          s2_q    <= wram_rdata[7:0];
          state_q <= S_DS_R2;
        end
        S_DS_R2: begin
          w1v_q[cur_e_q] <= oois_pkg::reg_ok(s1_q) && ren_v_q[s1_q[oois_pkg::REG_W-1:0]];
          w1t_q[cur_e_q] <= rram_rdata;
          state_q        <= S_DS_R3;
        end
        S_DS_R3: begin
          w2v_q[cur_e_q] <= oois_pkg::reg_ok(s2_q) && ren_v_q[s2_q[oois_pkg::REG_W-1:0]];
          w2t_q[cur_e_q] <= rram_rdata;
          if (oois_pkg::reg_ok(dst_q)) ren_v_q[dst_q[oois_pkg::REG_W-1:0]] <= 1'b1;
          stage_q[cur_e_q] <= oois_pkg::ST_IS;
          iscount_q        <= iscount_q + 7'd1;
          moved_q          <= moved_q + 5'd1;
          pos_q            <= pos_q + 7'd1;
          state_q          <= S_DS_SCAN;
        end
        S_DEC_START: begin
          pos_q   <= '0;
          base_q  <= head_q + oois_pkg::idx_t'(count_q - 7'(dcount_q));
          state_q <= S_DEC_SCAN;
        end
        S_DEC_SCAN: begin
          if (pos_q == 7'(dcount_q)) begin
            state_q <= S_IDLE;
          end else begin
            if (stage_q[scan_e] == oois_pkg::ST_IF) stage_q[scan_e] <= oois_pkg::ST_ID;
            pos_q <= pos_q + 7'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.result_kind     = kind_q;
  assign out_o.seq_tag         = tag_q;
  assign out_o.unit_type       = unit_q;
  assign out_o.dest_out        = dout_q;
  assign out_o.src1_out        = s1out_q;
  assign out_o.src2_out        = s2out_q;
  assign out_o.fetch_cycle     = t0_q;
  assign out_o.decode_cycle    = t1_q;
  assign out_o.queue_cycle     = t2_q;
  assign out_o.exec_cycle      = t3_q;
  assign out_o.writeback_cycle = t4_q;
  assign out_o.last_of_run     = last_q;

  oois_ram #(
    .WIDTH (32),
    .DEPTH (oois_pkg::WRAM_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (wram_waddr),
    .wdata_i (wram_wdata),
    .re_i    (wram_re),
    .raddr_i (wram_raddr),
    .rdata_o (wram_rdata)
  );

  oois_ram #(
    .WIDTH (oois_pkg::WIN_W),
    .DEPTH (oois_pkg::REG_COUNT)
  ) u_rename_ram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (rram_waddr),
    .wdata_i (rram_wdata),
    .re_i    (rram_re),
    .raddr_i (rram_raddr),
    .rdata_o (rram_rdata)
  );

  // entries moved this tick sit in both lists until the dispatch walk ends
  `OOIS_ASSERT_HOLDS(a_count_bound, count_q <= 7'(WD))
  `OOIS_ASSERT_HOLDS(a_lists_in_window,
                     (8'(dcount_q) + 8'(iscount_q)) <= (8'(count_q) + 8'(moved_q)))
  `OOIS_ASSERT_IMPLIES(a_retire_head_done,
                       (state_q == S_RET_CAP) && (rk_q == oois_pkg::TS_REGS),
                       stage_q[head_q] == oois_pkg::ST_WB)

endmodule
`default_nettype wire
